// File: design/msrbd_pkg.sv
package msrbd_pkg;

  // Sizing
  localparam int unsigned DUTY_BITS       = 10;
  localparam int unsigned MAX_SPEED       = 100;
  localparam int unsigned SERVO_DUTY_BITS = 16;

  localparam int unsigned SPEED_W  = 7;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned SREQ_W   = 8;
  localparam int unsigned AREQ_W   = 9;
  localparam int unsigned ANGLE_W  = 8;
  localparam int unsigned PULSE_BITS = 15;

  localparam int unsigned PCT_FULL        = 100;
  localparam int unsigned SERVO_FRAME_US  = 20000;
  localparam int unsigned SERVO_CENTRE    = 90;
  localparam int unsigned SERVO_ANGLE_MAX = 180;

  localparam int unsigned BRIDGE_FULL = (1 << DUTY_BITS) - 1;
  localparam int unsigned SERVO_FULL  = (1 << SERVO_DUTY_BITS) - 1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SPEED = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DIR   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SERVO = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ESTOP = 3'd4;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_FWD   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_REV   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_BRAKE = 2'd2;
  localparam logic [DIR_W-1:0] DIR_COAST = 2'd3;

  // Config register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MAX = 2'd2;

  localparam logic [SPEED_W-1:0]    RAMP_STEP_RESET = 7'd5;
  localparam logic [PULSE_BITS-1:0] SERVO_MIN_RESET = 15'd500;
  localparam logic [PULSE_BITS-1:0] SERVO_MAX_RESET = 15'd2500;

  localparam longint unsigned SERVO_RESET_PULSE = 500 + (SERVO_CENTRE * (2500 - 500)) /
                                                  SERVO_ANGLE_MAX;
  localparam longint unsigned SERVO_DUTY_RESET  = (SERVO_RESET_PULSE * SERVO_FULL) /
                                                  SERVO_FRAME_US;

  // Bridge duty: speed * BRIDGE_FULL / 100 by reciprocal
  localparam int unsigned BX_W = SPEED_W + DUTY_BITS;
  localparam longint unsigned BRIDGE_RECIP = (64'd1 << BX_W) / PCT_FULL;
  localparam int unsigned BRIDGE_RECIP_W = $clog2(BRIDGE_RECIP + 1);

  // Servo angle scaling: angle * (max - min) / 180 by reciprocal
  localparam int unsigned SRV_DIFF_W = PULSE_BITS + 1;
  localparam int unsigned SRV_PROD_W = SRV_DIFF_W + ANGLE_W;
  localparam int unsigned SRV_MAG_W  = SRV_PROD_W - 1;
  localparam longint unsigned ANGLE_RECIP = (64'd1 << SRV_MAG_W) / SERVO_ANGLE_MAX;
  localparam int unsigned ANGLE_RECIP_W = $clog2(ANGLE_RECIP + 1);
  localparam int unsigned PULSE_S_W = PULSE_BITS + 3;

  // Servo duty: pulse * SERVO_FULL / 20000 by reciprocal
  localparam int unsigned SX_W = PULSE_BITS + SERVO_DUTY_BITS;
  localparam longint unsigned SERVO_RECIP = (64'd1 << SX_W) / SERVO_FRAME_US;
  localparam int unsigned SERVO_RECIP_W = $clog2(SERVO_RECIP + 1);

  // Cycles from decode to valid arithmetic registers
  localparam int unsigned SETTLE_CYCLES = 5;
  localparam int unsigned SETTLE_W = $clog2(SETTLE_CYCLES);

  // Stream packing
  localparam int unsigned IN_FIELD_W = SREQ_W + DIR_W + AREQ_W;
  localparam int unsigned IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_W = 2 * DUTY_BITS + 1 + 2 * SPEED_W + DIR_W + 2 +
                                        SERVO_DUTY_BITS;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SREQ_W-1:0] speed_request;
    logic [DIR_W-1:0]  drive_direction;
    logic [AREQ_W-1:0] servo_angle_request;
  } item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0]       leg_one_duty;
    logic [DUTY_BITS-1:0]       leg_two_duty;
    logic                       bridge_enable;
    logic [SPEED_W-1:0]         present_speed;
    logic [SPEED_W-1:0]         goal_speed;
    logic [DIR_W-1:0]           active_direction;
    logic                       motor_running_flag;
    logic                       reversal_waiting;
    logic [SERVO_DUTY_BITS-1:0] servo_duty;
  } result_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_calc;
  } ctrl_sts_t;

endpackage

// File: design/msrbd_ctrl.sv
module msrbd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  msrbd_pkg::ctrl_sts_t  sts_i,
  output msrbd_pkg::ctrl_cmd_t  cmd_o
);
  import msrbd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SETTLE = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [SETTLE_W-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        cnt_d        = '0;
        state_d      = sts_i.need_calc ? S_SETTLE : S_OUT;
      end
      S_SETTLE: begin
        cnt_d = cnt_q + SETTLE_W'(1);
        if (cnt_q == SETTLE_W'(SETTLE_CYCLES - 1)) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        // output slot free or being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/msrbd_dp.sv
module msrbd_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  msrbd_pkg::ctrl_cmd_t                   cmd_i,
  output msrbd_pkg::ctrl_sts_t                   sts_o,
  input  msrbd_pkg::item_t                       item_i,
  output msrbd_pkg::result_t                     result_o,
  input  logic                                   cfg_we_i,
  input  logic [msrbd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [msrbd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import msrbd_pkg::*;

  // config
  logic [SPEED_W-1:0]    ramp_q;
  logic [PULSE_BITS-1:0] smin_q, smax_q;

  // controller state of the drive
  logic [SPEED_W-1:0] goal_q, goal_d, pres_q, pres_d, saved_q, saved_d;
  logic [DIR_W-1:0]   dir_q, dir_d, pend_q, pend_d;
  logic               rev_q, rev_d, run_q, run_d;

  // latched outputs
  logic [DUTY_BITS-1:0]       leg1_q, leg2_q;
  logic                       en_q;
  logic [SERVO_DUTY_BITS-1:0] servo_q;

  item_t   item_q;
  result_t out_q;

  // decoded work for the arithmetic
  logic               lat_en_q, lat_en_d, srv_en_q, srv_en_d;
  logic [SPEED_W-1:0] lat_spd_q, lat_spd_d;
  logic [DIR_W-1:0]   lat_dir_q, lat_dir_d;
  logic [ANGLE_W-1:0] srv_ang_q, srv_ang_d, ang_clamped;

  logic [SPEED_W-1:0] step, np, spd;
  logic [SPEED_W:0]   sum8, gstep8;
  logic               swap;

  always_comb begin
    if (item_q.servo_angle_request[AREQ_W-1]) begin
      ang_clamped = '0;
    end else if (item_q.servo_angle_request[ANGLE_W-1:0] > ANGLE_W'(SERVO_ANGLE_MAX)) begin
      ang_clamped = ANGLE_W'(SERVO_ANGLE_MAX);
    end else begin
      ang_clamped = item_q.servo_angle_request[ANGLE_W-1:0];
    end

    if (item_q.speed_request[SREQ_W-1]) begin
      spd = '0;
    end else if (item_q.speed_request[SPEED_W-1:0] > SPEED_W'(MAX_SPEED)) begin
      spd = SPEED_W'(MAX_SPEED);
    end else begin
      spd = item_q.speed_request[SPEED_W-1:0];
    end

    step   = (ramp_q == '0) ? SPEED_W'(1) : ramp_q;
    sum8   = {1'b0, pres_q} + {1'b0, step};
    gstep8 = {1'b0, goal_q} + {1'b0, step};
    swap   = ((dir_q == DIR_FWD) && (item_q.drive_direction == DIR_REV)) ||
             ((dir_q == DIR_REV) && (item_q.drive_direction == DIR_FWD));
    np     = pres_q;

    goal_d    = goal_q;
    pres_d    = pres_q;
    saved_d   = saved_q;
    dir_d     = dir_q;
    pend_d    = pend_q;
    rev_d     = rev_q;
    run_d     = run_q;
    lat_en_d  = 1'b0;
    lat_spd_d = pres_q;
    lat_dir_d = dir_q;
    srv_en_d  = 1'b0;
    srv_ang_d = ang_clamped;

    case (item_q.req_type)
      REQ_TICK: begin
        if (pres_q < goal_q) begin
          np       = (sum8 > {1'b0, goal_q}) ? goal_q : sum8[SPEED_W-1:0];
          lat_en_d = 1'b1;
        end else if (pres_q > goal_q) begin
          np       = ({1'b0, pres_q} > gstep8) ? pres_q - step : goal_q;
          lat_en_d = 1'b1;
        end
        pres_d    = np;
        lat_spd_d = np;
        // reversal completes once stopped in the old direction
        if (rev_q && (np == '0)) begin
          dir_d  = pend_q;
          goal_d = saved_q;
          rev_d  = 1'b0;
        end
      end
      REQ_SPEED: begin
        if (rev_q) begin
          saved_d = spd;
        end else begin
          goal_d = spd;
        end
        run_d = (spd != '0);
      end
      REQ_DIR: begin
        if (rev_q) begin
          if ((item_q.drive_direction == DIR_FWD) || (item_q.drive_direction == DIR_REV)) begin
            if (item_q.drive_direction == dir_q) begin
              goal_d = saved_q;
              rev_d  = 1'b0;
            end else begin
              pend_d = item_q.drive_direction;
            end
          end else begin
            goal_d    = saved_q;
            rev_d     = 1'b0;
            dir_d     = item_q.drive_direction;
            lat_en_d  = 1'b1;
            lat_dir_d = item_q.drive_direction;
          end
        end else if (swap && (pres_q != '0)) begin
          rev_d   = 1'b1;
          pend_d  = item_q.drive_direction;
          saved_d = goal_q;
          goal_d  = '0;
        end else begin
          dir_d = item_q.drive_direction;
          if ((item_q.drive_direction == DIR_BRAKE) ||
              (item_q.drive_direction == DIR_COAST)) begin
            lat_en_d  = 1'b1;
            lat_dir_d = item_q.drive_direction;
          end
        end
      end
      REQ_SERVO: begin
        srv_en_d = 1'b1;
      end
      REQ_ESTOP: begin
        goal_d    = '0;
        pres_d    = '0;
        dir_d     = DIR_BRAKE;
        run_d     = 1'b0;
        rev_d     = 1'b0;
        lat_en_d  = 1'b1;
        lat_spd_d = '0;
        lat_dir_d = DIR_BRAKE;
        srv_en_d  = 1'b1;
        srv_ang_d = ANGLE_W'(SERVO_CENTRE);
      end
      default: begin
      end
    endcase
  end

  assign sts_o.need_calc = lat_en_d | srv_en_d;

  // ---- bridge duty pipeline ----
  logic [BX_W-1:0]                bx_q, bq_q, brem, bduty;
  logic [BX_W+BRIDGE_RECIP_W-1:0] bprod;
  logic [DUTY_BITS-1:0]           duty;

  assign bprod = (BX_W+BRIDGE_RECIP_W)'(bx_q) * (BX_W+BRIDGE_RECIP_W)'(BRIDGE_RECIP);
  assign brem  = bx_q - bq_q * BX_W'(PCT_FULL);
  assign bduty = (brem >= BX_W'(PCT_FULL)) ? bq_q + BX_W'(1) : bq_q;
  assign duty  = (bduty > BX_W'(BRIDGE_FULL)) ? DUTY_BITS'(BRIDGE_FULL)
                                              : bduty[DUTY_BITS-1:0];

  // ---- servo pipeline ----
  logic signed [SRV_DIFF_W-1:0]     sdiff;
  logic signed [SRV_PROD_W-1:0]     sprod_q, sprod_d;
  logic [SRV_PROD_W-1:0]            sabs;
  logic [SRV_MAG_W-1:0]             amag_q, aq0_q, arem, aq;
  logic [SRV_MAG_W+ANGLE_RECIP_W-1:0] amul;
  logic                             asign_q;
  logic signed [PULSE_S_W-1:0]      aq_s, spulse;
  logic [PULSE_BITS-1:0]            pulse_q;
  logic                             psat_q;
  logic [SX_W-1:0]                  sx_q, sq0_q, srem, sduty;
  logic [SX_W+SERVO_RECIP_W-1:0]    smul;
  logic [SERVO_DUTY_BITS-1:0]       servo_duty;

  assign sdiff   = $signed({1'b0, smax_q}) - $signed({1'b0, smin_q});
  assign sprod_d = $signed({1'b0, srv_ang_q}) * sdiff;
  assign sabs    = sprod_q[SRV_PROD_W-1] ? (~sprod_q + SRV_PROD_W'(1)) : sprod_q;
  assign amul    = (SRV_MAG_W+ANGLE_RECIP_W)'(sabs[SRV_MAG_W-1:0]) *
                   (SRV_MAG_W+ANGLE_RECIP_W)'(ANGLE_RECIP);
  assign arem    = amag_q - aq0_q * SRV_MAG_W'(SERVO_ANGLE_MAX);
  assign aq      = (arem >= SRV_MAG_W'(SERVO_ANGLE_MAX)) ? aq0_q + SRV_MAG_W'(1) : aq0_q;
  assign aq_s    = $signed(PULSE_S_W'(aq));
  assign spulse  = $signed(PULSE_S_W'(smin_q)) + (asign_q ? -aq_s : aq_s);
  assign smul    = (SX_W+SERVO_RECIP_W)'(sx_q) * (SX_W+SERVO_RECIP_W)'(SERVO_RECIP);
  assign srem    = sx_q - sq0_q * SX_W'(SERVO_FRAME_US);
  assign sduty   = (srem >= SX_W'(SERVO_FRAME_US)) ? sq0_q + SX_W'(1) : sq0_q;
  assign servo_duty = psat_q ? SERVO_DUTY_BITS'(SERVO_FULL) : sduty[SERVO_DUTY_BITS-1:0];

  // free-running arithmetic registers; inputs hold steady through an item
  always_ff @(posedge clk_i) begin
    bx_q    <= BX_W'(lat_spd_q) * BX_W'(BRIDGE_FULL);
    bq_q    <= BX_W'(bprod >> BX_W);
    sprod_q <= sprod_d;
    asign_q <= sprod_q[SRV_PROD_W-1];
    amag_q  <= sabs[SRV_MAG_W-1:0];
    aq0_q   <= SRV_MAG_W'(amul >> SRV_MAG_W);
    pulse_q <= spulse[PULSE_S_W-1] ? '0 : spulse[PULSE_BITS-1:0];
    psat_q  <= !spulse[PULSE_S_W-1] &&
               (spulse > $signed(PULSE_S_W'(SERVO_FRAME_US)));
    sx_q    <= SX_W'(pulse_q) * SX_W'(SERVO_FULL);
    sq0_q   <= SX_W'(smul >> SX_W);
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.decode) begin
      lat_spd_q <= lat_spd_d;
      lat_dir_q <= lat_dir_d;
      srv_ang_q <= srv_ang_d;
    end
    if (cmd_i.load_out) begin
      out_q.leg_one_duty       <= leg1_q;
      out_q.leg_two_duty       <= leg2_q;
      out_q.bridge_enable      <= en_q;
      out_q.present_speed      <= pres_q;
      out_q.goal_speed         <= goal_q;
      out_q.active_direction   <= dir_q;
      out_q.motor_running_flag <= run_q;
      out_q.reversal_waiting   <= rev_q;
      out_q.servo_duty         <= servo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q   <= RAMP_STEP_RESET;
      smin_q   <= SERVO_MIN_RESET;
      smax_q   <= SERVO_MAX_RESET;
      goal_q   <= '0;
      pres_q   <= '0;
      saved_q  <= '0;
      dir_q    <= DIR_COAST;
      pend_q   <= DIR_FWD;
      rev_q    <= 1'b0;
      run_q    <= 1'b0;
      lat_en_q <= 1'b0;
      srv_en_q <= 1'b0;
      leg1_q   <= '0;
      leg2_q   <= '0;
      en_q     <= 1'b0;
      servo_q  <= SERVO_DUTY_BITS'(SERVO_DUTY_RESET);
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RAMP_STEP: ramp_q <= cfg_data_i[SPEED_W-1:0];
          CFG_SERVO_MIN: smin_q <= cfg_data_i;
          CFG_SERVO_MAX: smax_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.decode) begin
        goal_q   <= goal_d;
        pres_q   <= pres_d;
        saved_q  <= saved_d;
        dir_q    <= dir_d;
        pend_q   <= pend_d;
        rev_q    <= rev_d;
        run_q    <= run_d;
        lat_en_q <= lat_en_d;
        srv_en_q <= srv_en_d;
      end
      if (cmd_i.commit) begin
        if (lat_en_q) begin
          case (lat_dir_q)
            DIR_FWD: begin
              leg1_q <= duty;
              leg2_q <= '0;
              en_q   <= 1'b1;
            end
            DIR_REV: begin
              leg1_q <= '0;
              leg2_q <= duty;
              en_q   <= 1'b1;
            end
            DIR_BRAKE: begin
              leg1_q <= DUTY_BITS'(BRIDGE_FULL);
              leg2_q <= DUTY_BITS'(BRIDGE_FULL);
              en_q   <= 1'b1;
            end
            default: begin
              leg1_q <= '0;
              leg2_q <= '0;
              en_q   <= 1'b0;
            end
          endcase
        end
        if (srv_en_q) begin
          servo_q <= servo_duty;
        end
      end
    end
  end

  assign result_o = out_q;

endmodule

// File: design/motor_speed_ramp_bridge_driver_top.sv
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tuser: req_type; tdata: speed, direction, angle
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata: bridge, speed, status, servo fields
// cfg      in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// Steps: an item that latches nothing (speed set, direction set without a bridge change,
// ramp tick at goal, unused code) goes from accept to accept through decode, output load, idle.
// One that latches the bridge or the servo adds a settle state for the registered
// reciprocal-multiply chains of the bridge and servo maps, then a commit state.
// Reset (async, active low) clears the drive state to coast, config to its defaults.
// A stalled m_axis holds the result in its register; the next item is still taken and
// waits only at its output step.
module motor_speed_ramp_bridge_driver_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // slave stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [7:0] speed_request, [9:8] drive_direction, [18:10] servo_angle_request
  input  logic [msrbd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [2:0] req_type
  input  logic [msrbd_pkg::REQ_W-1:0]           s_axis_tuser,
  // master stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [9:0] leg_one_duty, [19:10] leg_two_duty, [20] bridge_enable,
  // [27:21] present_speed, [34:28] goal_speed, [36:35] active_direction,
  // [37] motor_running_flag, [38] reversal_waiting, [54:39] servo_duty
  output logic [msrbd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // config write
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [msrbd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [msrbd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import msrbd_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  item_t     item;
  result_t   res;

  // unpack the incoming item
  assign item.req_type            = s_axis_tuser;
  assign item.speed_request       = s_axis_tdata[SREQ_W-1:0];
  assign item.drive_direction     = s_axis_tdata[SREQ_W+DIR_W-1:SREQ_W];
  assign item.servo_angle_request = s_axis_tdata[IN_FIELD_W-1:SREQ_W+DIR_W];

  // config registers take a write any cycle
  assign cfg_ready_o = 1'b1;

  msrbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  msrbd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item),
    .result_o    (res),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // pack result, first field lowest, zero fill to whole bytes
  assign m_axis_tdata = OUT_DATA_W'({res.servo_duty,
                                     res.reversal_waiting,
                                     res.motor_running_flag,
                                     res.active_direction,
                                     res.goal_speed,
                                     res.present_speed,
                                     res.bridge_enable,
                                     res.leg_two_duty,
                                     res.leg_one_duty});

endmodule

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msrbd_pkg::*;

  // Bit offsets of the result fields inside m_axis_tdata, lowest field first
  localparam int OFF_LEG_TWO = DUTY_BITS;
  localparam int OFF_ENABLE  = 2 * DUTY_BITS;
  localparam int OFF_PRESENT = OFF_ENABLE + 1;
  localparam int OFF_GOAL    = OFF_PRESENT + SPEED_W;
  localparam int OFF_DIR     = OFF_GOAL + SPEED_W;
  localparam int OFF_RUNNING = OFF_DIR + DIR_W;
  localparam int OFF_REVERSE = OFF_RUNNING + 1;
  localparam int OFF_SERVO   = OFF_REVERSE + 1;

  // Request codes the block decodes as no-ops
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_W'(REQ_ESTOP + 1);
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = '1;

  // Quiet time let pass after the last result, longer than the slowest item
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int ITEMS_PER_PHASE = 255;

  // ---------------------------------------------------------------------------
  // Expected-output tracker: mirrors the drive state and queues one result
  // per accepted item, in order.
  // ---------------------------------------------------------------------------
  class bridge_state_tracker;
    int ramp_step, pulse_lo, pulse_hi;
    int goal_pct, cur_pct, held_goal;
    logic [DIR_W-1:0] dir_now, dir_next;
    bit reversing, running, bridge_on;
    int leg_one, leg_two, servo_duty;
    result_t due_outputs[$];
    int errors;

    function new();
      ramp_step  = int'(RAMP_STEP_RESET);
      pulse_lo   = int'(SERVO_MIN_RESET);
      pulse_hi   = int'(SERVO_MAX_RESET);
      goal_pct   = 0;
      cur_pct    = 0;
      held_goal  = 0;
      dir_now    = DIR_COAST;
      dir_next   = DIR_FWD;
      reversing  = 0;
      running    = 0;
      bridge_on  = 0;
      leg_one    = 0;
      leg_two    = 0;
      errors     = 0;
      servo_duty = servo_for(SERVO_CENTRE);
    endfunction

    function int outstanding();
      return due_outputs.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_RAMP_STEP: ramp_step = int'(val[SPEED_W-1:0]);
        CFG_SERVO_MIN: pulse_lo  = int'(val[PULSE_BITS-1:0]);
        CFG_SERVO_MAX: pulse_hi  = int'(val[PULSE_BITS-1:0]);
        default: ;
      endcase
    endfunction

    // Angle clamp, linear pulse map (may run downward), then duty at 20 ms
    function int servo_for(int angle);
      longint pulse, duty;
      if (angle < 0) angle = 0;
      if (angle > int'(SERVO_ANGLE_MAX)) angle = SERVO_ANGLE_MAX;
      pulse = longint'(pulse_lo) +
              (longint'(angle) * (longint'(pulse_hi) - longint'(pulse_lo))) /
              longint'(SERVO_ANGLE_MAX);
      if (pulse < 0) pulse = 0;
      duty = (pulse * longint'(SERVO_FULL)) / longint'(SERVO_FRAME_US);
      if (duty > longint'(SERVO_FULL)) duty = SERVO_FULL;
      return int'(duty);
    endfunction

    function void latch(int pct, logic [DIR_W-1:0] d);
      int duty;
      duty = (pct * int'(BRIDGE_FULL)) / int'(PCT_FULL);
      if (duty > int'(BRIDGE_FULL)) duty = BRIDGE_FULL;
      case (d)
        DIR_FWD: begin
          leg_one = duty; leg_two = 0; bridge_on = 1;
        end
        DIR_REV: begin
          leg_one = 0; leg_two = duty; bridge_on = 1;
        end
        DIR_BRAKE: begin
          leg_one = BRIDGE_FULL; leg_two = BRIDGE_FULL; bridge_on = 1;
        end
        default: begin
          leg_one = 0; leg_two = 0; bridge_on = 0;
        end
      endcase
    endfunction

    function void take_command(logic [REQ_W-1:0] req, logic [SREQ_W-1:0] spd_raw,
                               logic [DIR_W-1:0] nd, logic [AREQ_W-1:0] ang_raw);
      int step, pct;
      result_t want;
      case (req)
        REQ_TICK: begin
          step = (ramp_step != 0) ? ramp_step : 1;
          if (cur_pct < goal_pct) begin
            cur_pct = (cur_pct + step > goal_pct) ? goal_pct : cur_pct + step;
            latch(cur_pct, dir_now);
          end else if (cur_pct > goal_pct) begin
            cur_pct = (cur_pct > goal_pct + step) ? cur_pct - step : goal_pct;
            latch(cur_pct, dir_now);
          end
          // ramp-down before a reversal is over: swap and resume
          if (reversing && cur_pct == 0) begin
            dir_now   = dir_next;
            goal_pct  = held_goal;
            reversing = 0;
          end
        end
        REQ_SPEED: begin
          pct = $signed(spd_raw);
          if (pct < 0) pct = 0;
          if (pct > int'(MAX_SPEED)) pct = MAX_SPEED;
          if (reversing) held_goal = pct;
          else goal_pct = pct;
          running = (pct > 0);
        end
        REQ_DIR: begin
          if (reversing) begin
            if (nd == DIR_FWD || nd == DIR_REV) begin
              if (nd == dir_now) begin
                goal_pct  = held_goal;
                reversing = 0;
              end else begin
                dir_next = nd;
              end
            end else begin
              goal_pct  = held_goal;
              reversing = 0;
              dir_now   = nd;
              latch(cur_pct, nd);
            end
          end else if (((dir_now == DIR_FWD && nd == DIR_REV) ||
                        (dir_now == DIR_REV && nd == DIR_FWD)) && cur_pct > 0) begin
            reversing = 1;
            dir_next  = nd;
            held_goal = goal_pct;
            goal_pct  = 0;
          end else begin
            dir_now = nd;
            if (nd == DIR_BRAKE || nd == DIR_COAST) latch(cur_pct, nd);
          end
        end
        REQ_SERVO: servo_duty = servo_for($signed(ang_raw));
        REQ_ESTOP: begin
          goal_pct   = 0;
          cur_pct    = 0;
          dir_now    = DIR_BRAKE;
          running    = 0;
          reversing  = 0;
          latch(0, DIR_BRAKE);
          servo_duty = servo_for(SERVO_CENTRE);
        end
        default: ;
      endcase
      want.leg_one_duty       = DUTY_BITS'(leg_one);
      want.leg_two_duty       = DUTY_BITS'(leg_two);
      want.bridge_enable      = bridge_on;
      want.present_speed      = SPEED_W'(cur_pct);
      want.goal_speed         = SPEED_W'(goal_pct);
      want.active_direction   = dir_now;
      want.motor_running_flag = running;
      want.reversal_waiting   = reversing;
      want.servo_duty         = SERVO_DUTY_BITS'(servo_duty);
      due_outputs.push_back(want);
    endfunction

    function void match(string fld, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, seen);
      end
    endfunction

    function void compare_output(logic [OUT_DATA_W-1:0] raw);
      result_t want;
      if (due_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, raw);
        return;
      end
      want = due_outputs.pop_front();
      match("leg_one_duty", want.leg_one_duty, raw[DUTY_BITS-1:0]);
      match("leg_two_duty", want.leg_two_duty, raw[OFF_LEG_TWO +: DUTY_BITS]);
      match("bridge_enable", want.bridge_enable, raw[OFF_ENABLE]);
      match("present_speed", want.present_speed, raw[OFF_PRESENT +: SPEED_W]);
      match("goal_speed", want.goal_speed, raw[OFF_GOAL +: SPEED_W]);
      match("active_direction", want.active_direction, raw[OFF_DIR +: DIR_W]);
      match("motor_running_flag", want.motor_running_flag, raw[OFF_RUNNING]);
      match("reversal_waiting", want.reversal_waiting, raw[OFF_REVERSE]);
      match("servo_duty", want.servo_duty, raw[OFF_SERVO +: SERVO_DUTY_BITS]);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  motor_speed_ramp_bridge_driver_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  bridge_state_tracker tracker;
  bit steady = 1'b0;     // when set, neither side idles
  int sink_hold = 0;
  int cycles = 0;

  always #6 clk_i = ~clk_i;

  // Gap length shared by sender and receiver: mostly short, now and then long
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver back-pressure, changed on the falling edge
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
    end else if (steady || $urandom_range(0, 2) != 0) begin
      m_axis_tready <= 1'b1;
      sink_hold = $urandom_range(0, 6);
    end else begin
      m_axis_tready <= 1'b0;
      sink_hold = idle_len();
    end
  end

  // Both handshakes sampled at the rising edge; input noted before output
  // is checked, since a result never leaves in its own item's accept cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker.take_command(s_axis_tuser, s_axis_tdata[SREQ_W-1:0],
                             s_axis_tdata[SREQ_W +: DIR_W],
                             s_axis_tdata[SREQ_W+DIR_W +: AREQ_W]);
      if (m_axis_tvalid && m_axis_tready)
        tracker.compare_output(m_axis_tdata);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** motor_speed_ramp_bridge_driver_top: FAILED **");
      $finish;
    end
  end

  // Drive one item; called and returning on a falling edge. tvalid stays
  // high into the next item when no gap follows.
  task automatic push_item(input logic [REQ_W-1:0] req, input logic [SREQ_W-1:0] spd,
                           input logic [DIR_W-1:0] d, input logic [AREQ_W-1:0] ang);
    int gap;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {{(IN_DATA_W-IN_FIELD_W){1'b0}}, ang, d, spd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Random item: every field fully random, the field the command uses mostly
  // in its legal range so that ramps and reversals actually develop.
  task automatic push_random();
    logic [REQ_W-1:0]  req;
    logic [SREQ_W-1:0] spd;
    logic [DIR_W-1:0]  d;
    logic [AREQ_W-1:0] ang;
    int r;
    spd = SREQ_W'($urandom);
    d   = DIR_W'($urandom);
    ang = AREQ_W'($urandom);
    r   = $urandom_range(0, 99);
    if (r < 50) begin
      req = REQ_TICK;
    end else if (r < 64) begin
      req = REQ_SPEED;
      if ($urandom_range(0, 3) != 0) spd = SREQ_W'($urandom_range(0, MAX_SPEED));
    end else if (r < 80) begin
      req = REQ_DIR;
      if ($urandom_range(0, 3) != 0) d = DIR_W'($urandom_range(DIR_FWD, DIR_REV));
    end else if (r < 88) begin
      req = REQ_SERVO;
      if ($urandom_range(0, 1) != 0) ang = AREQ_W'($urandom_range(0, SERVO_ANGLE_MAX));
    end else if (r < 91) begin
      req = REQ_ESTOP;
    end else begin
      req = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
    end
    push_item(req, spd, d, ang);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stop sending, wait for every result, then let the pipeline go quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic reconfigure(input int step, input int lo, input int hi);
    drain();
    write_cfg(CFG_RAMP_STEP, CFG_DATA_W'(step));
    write_cfg(CFG_SERVO_MIN, CFG_DATA_W'(lo));
    write_cfg(CFG_SERVO_MAX, CFG_DATA_W'(hi));
  endtask

  task automatic random_phase();
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 4) == 0);
      push_random();
    end
  endtask

  initial begin
    tracker = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, reset configuration (step 5, 500..2500 us)
    push_item(REQ_TICK,  8'h00, DIR_FWD, 9'h000);    // tick at rest, nothing moves
    push_item(REQ_SPEED, 8'h7F, DIR_FWD, 9'h000);    // clamps to full speed
    push_item(REQ_DIR,   8'h00, DIR_FWD, 9'h000);    // coast -> forward at rest
    repeat (3) push_item(REQ_TICK, 8'h00, DIR_FWD, 9'h000);
    push_item(REQ_DIR,   8'h00, DIR_REV, 9'h000);    // reversal wait starts
    push_item(REQ_SPEED, 8'h80, DIR_FWD, 9'h000);    // negative -> saved goal 0
    push_item(REQ_SPEED, 8'd60, DIR_FWD, 9'h000);    // saved goal updated
    push_item(REQ_DIR,   8'h00, DIR_FWD, 9'h000);    // back to old dir cancels
    push_item(REQ_DIR,   8'h00, DIR_REV, 9'h000);    // wait again
    push_item(REQ_DIR,   8'h00, DIR_REV, 9'h000);    // pending replaced
    repeat (3) push_item(REQ_TICK, 8'h00, DIR_FWD, 9'h000);  // reaches 0, swaps
    repeat (2) push_item(REQ_TICK, 8'h00, DIR_FWD, 9'h000);  // ramp up in reverse
    push_item(REQ_DIR,   8'h00, DIR_FWD, 9'h000);    // wait toward forward
    push_item(REQ_DIR,   8'h00, DIR_BRAKE, 9'h000);  // brake cancels, latches now
    push_item(REQ_DIR,   8'h00, DIR_COAST, 9'h000);
    push_item(REQ_SERVO, 8'h00, DIR_FWD, 9'h100);    // most negative angle
    push_item(REQ_SERVO, 8'h00, DIR_FWD, 9'h0FF);    // above 180
    push_item(REQ_SERVO, 8'h00, DIR_FWD, 9'd0);
    push_item(REQ_SERVO, 8'h00, DIR_FWD, 9'd180);
    push_item(REQ_ESTOP, 8'hFF, DIR_COAST, 9'h1FF);
    push_item(REQ_SPARE_FIRST, 8'hFF, DIR_COAST, 9'h1FF);
    push_item(REQ_SPARE_LAST,  8'h55, DIR_REV, 9'h0AA);

    random_phase();

    // Smallest step, servo span over the whole 20 ms frame
    reconfigure(1, 0, 20000);
    random_phase();
    // Largest legal step, servo map running downward
    reconfigure(100, 20000, 0);
    random_phase();
    // Zero step acts as one; pulses past the period saturate the duty
    reconfigure(0, 15'h7FFF, 15'h7FFF);
    random_phase();
    // Full 7-bit step, widest raw span
    reconfigure(7'h7F, 0, 15'h7FFF);
    random_phase();
    reconfigure($urandom_range(0, 15'h7FFF), $urandom_range(0, 15'h7FFF),
                $urandom_range(0, 15'h7FFF));
    random_phase();

    drain();
    if (tracker.errors == 0) begin
      $display("** motor_speed_ramp_bridge_driver_top: PASSED **");
    end else begin
      $display("** motor_speed_ramp_bridge_driver_top: FAILED **");
    end
    $finish;
  end

endmodule
